/* hw/rtl/genotype_ld_r2_macros.svh */
// Assertion macros for the RTL file that checks itself.
`ifndef GENOTYPE_LD_R2_MACROS_SVH
`define GENOTYPE_LD_R2_MACROS_SVH

// Same-cycle implication.
`define GLD_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define GLD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/gld_pkg.sv */
package gld_pkg;

   localparam int QF = 24;
   localparam int DEN_W = 25;

   localparam logic signed [31:0] Q_ONE  = 32'sd16777216;
   localparam logic signed [31:0] Q_EPS  = 32'sd16777;
   localparam logic signed [63:0] Q_HALF = 64'sd8388608;
   localparam logic signed [63:0] Q_TWO  = 64'sd33554432;
   localparam logic signed [63:0] Q_FOUR = 64'sd67108864;

   localparam logic [6:0] PCT_MAX = 7'd100;
   localparam logic [1:0] GENO_MISSING = 2'd3;

   localparam logic CSR_MIN_COV = 1'b0;
   localparam logic CSR_MIN_R2  = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK,
      STAT_LOW_COV,
      STAT_FIXED,
      STAT_WEAK
   } status_type;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_QMUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

   typedef struct packed {
      logic       valid;
      logic [6:0] ld;
      logic [6:0] cov;
      status_type status;
   } result_type;

   typedef enum logic [2:0] {
      A_IDLE,
      A_PROD,
      A_DADJ,
      A_DIV,
      A_DSGN,
      A_DONE
   } alu_state_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CHECK,
      S_P1,
      S_P2,
      S_PQ,
      S_CB_M,
      S_CB_D,
      S_CC_M1,
      S_CC_M2,
      S_CC_M3,
      S_CC_D,
      S_CD_M,
      S_CD_D,
      S_LO,
      S_HI,
      S_MID,
      S_X2,
      S_X3,
      S_BX2,
      S_CX,
      S_EVAL,
      S_V1,
      S_V2,
      S_VCHK,
      S_DD_M,
      S_R2A,
      S_R2B,
      S_FLOOR,
      S_FCHK,
      S_LD,
      S_COV,
      S_OUT
   } solver_state_type;

endpackage

/* hw/rtl/gld_count.sv */
module gld_count #(
   parameter int MAX_SITES = 512,
   parameter int CNT_W     = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       inc,
   input  logic                       clear,
   input  logic [1:0]                 geno_a,
   input  logic [1:0]                 geno_b,
   output logic [CNT_W-1:0]           site_count,
   output logic [CNT_W-1:0]           called_count,
   output logic [8:0][CNT_W-1:0]      pair_counts
);

   logic [CNT_W-1:0]      site_ff, site_in;
   logic [CNT_W-1:0]      called_ff, called_in;
   logic [8:0][CNT_W-1:0] pc_ff, pc_in;
   logic [3:0]            idx;
   logic                  called;
   logic                  take;

   assign idx    = 4'(geno_a) * 4'd3 + 4'(geno_b);
   assign called = (geno_a != gld_pkg::GENO_MISSING) && (geno_b != gld_pkg::GENO_MISSING);
   // drop sites once the run is full
   assign take   = inc && (site_ff < CNT_W'(MAX_SITES));

   always_comb begin
      site_in   = site_ff;
      called_in = called_ff;
      pc_in     = pc_ff;
      if (clear) begin
         site_in   = '0;
         called_in = '0;
         pc_in     = '0;
      end else if (take) begin
         site_in = site_ff + 1'b1;
         if (called) begin
            called_in = called_ff + 1'b1;
            for (int i = 0; i < 9; i++) begin
               if (idx == 4'(i)) begin
                  pc_in[i] = pc_ff[i] + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         site_ff   <= '0;
         called_ff <= '0;
         pc_ff     <= '0;
      end else begin
         site_ff   <= site_in;
         called_ff <= called_in;
         pc_ff     <= pc_in;
      end
   end

   assign site_count   = site_ff;
   assign called_count = called_ff;
   assign pair_counts  = pc_ff;

endmodule

/* hw/rtl/gld_alu.sv */
module gld_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  gld_pkg::alu_req_type req,
   input  logic signed [63:0]   opa,
   input  logic signed [31:0]   opb,
   output logic                 done,
   output logic signed [63:0]   result
);

   gld_pkg::alu_state_type    state_ff, state_in;
   gld_pkg::alu_op_type       op_ff;
   logic signed [63:0]        prod_ff;
   logic signed [63:0]        res_ff;
   logic [63:0]               dvd_ff;
   logic [gld_pkg::DEN_W-1:0] den_ff;
   logic [gld_pkg::DEN_W-1:0] rem_ff;
   logic [5:0]                cnt_ff;
   logic                      neg_ff;

   logic signed [31:0]        opa_lo;
   logic signed [63:0]        prod_c;
   logic [63:0]               mag_c;
   logic signed [63:0]        rnd_c;
   logic [gld_pkg::DEN_W:0]   rem_sh;
   logic [gld_pkg::DEN_W:0]   rem_sub;
   logic                      ge;

   always_comb begin
      opa_lo  = opa[31:0];
      prod_c  = opa_lo * opb;
      mag_c   = opa[63] ? 64'(-opa) : 64'(opa);
      // ties away from zero: bias toward zero by one on the negative side
      rnd_c   = (prod_ff + (prod_ff[63] ? gld_pkg::Q_HALF - 64'sd1 : gld_pkg::Q_HALF))
                >>> gld_pkg::QF;
      rem_sh  = {rem_ff, dvd_ff[63]};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_sub = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gld_pkg::A_IDLE: begin
            if (req.start) begin
               state_in = (req.op == gld_pkg::ALU_DIV) ? gld_pkg::A_DADJ : gld_pkg::A_PROD;
            end
         end
         gld_pkg::A_PROD: state_in = gld_pkg::A_DONE;
         gld_pkg::A_DADJ: state_in = gld_pkg::A_DIV;
         gld_pkg::A_DIV: begin
            if (cnt_ff == 6'd63) begin
               state_in = gld_pkg::A_DSGN;
            end
         end
         gld_pkg::A_DSGN: state_in = gld_pkg::A_DONE;
         gld_pkg::A_DONE: state_in = gld_pkg::A_IDLE;
         default:         state_in = gld_pkg::A_IDLE;
      endcase
   end

   always_comb begin
      done   = (state_ff == gld_pkg::A_DONE);
      result = res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gld_pkg::A_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         gld_pkg::A_IDLE: begin
            if (req.start) begin
               op_ff   <= req.op;
               prod_ff <= prod_c;
               neg_ff  <= opa[63];
               dvd_ff  <= mag_c;
               den_ff  <= opb[gld_pkg::DEN_W-1:0];
            end
         end
         gld_pkg::A_PROD: begin
            res_ff <= (op_ff == gld_pkg::ALU_QMUL) ? rnd_c : prod_ff;
         end
         gld_pkg::A_DADJ: begin
            // add half the divisor for round to nearest
            dvd_ff <= dvd_ff + 64'(den_ff >> 1);
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         gld_pkg::A_DIV: begin
            dvd_ff <= {dvd_ff[62:0], ge};
            rem_ff <= rem_sub[gld_pkg::DEN_W-1:0];
            cnt_ff <= cnt_ff + 6'd1;
         end
         gld_pkg::A_DSGN: begin
            res_ff <= neg_ff ? -$signed(dvd_ff) : $signed(dvd_ff);
         end
         default: ;
      endcase
   end

endmodule

/* hw/rtl/gld_solve.sv */
module gld_solve #(
   parameter int CNT_W        = 10,
   parameter int BISECT_STEPS = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    slot_free,
   input  logic [CNT_W-1:0]        site_count,
   input  logic [CNT_W-1:0]        called_count,
   input  logic [8:0][CNT_W-1:0]   pair_counts,
   input  logic [6:0]              min_cov,
   input  logic [6:0]              min_r2,
   input  logic                    alu_done,
   input  logic signed [63:0]      alu_res,
   output gld_pkg::alu_req_type    alu_req,
   output logic signed [63:0]      alu_a,
   output logic signed [31:0]      alu_b,
   output gld_pkg::result_type     result,
   output logic                    idle
);

   localparam int NUM_W = CNT_W + 1;
   localparam int KW    = $clog2(BISECT_STEPS + 1);

   gld_pkg::solver_state_type state_ff, state_in;
   gld_pkg::status_type       status_ff;
   logic                      wait_ff;
   logic [NUM_W-1:0]          s_ff, n22_ff;
   logic signed [31:0]        p1_ff, p2_ff, t_ff, pq_ff, cb_ff, cc_ff, cd_ff;
   logic signed [31:0]        lo_ff, hi_ff, mid_ff, x2_ff, dd_ff, v1_ff, v2_ff, r2_ff;
   logic signed [63:0]        tmp_ff, acc_ff;
   logic [KW-1:0]             k_ff;
   logic [6:0]                ld_ff, cov_ff;

   logic [NUM_W-1:0]          r0, r1, c0, c1, num1_c, num2_c, s_c, n2;
   logic [CNT_W+1:0]          n4;
   logic [NUM_W-1:0]          tot2;
   logic [NUM_W:0]            sn;
   logic [CNT_W+6:0]          cov_lhs, cov_rhs;
   logic                      cov_low, fixed, narrow, bad_v, r2_low;
   logic signed [32:0]        mid_sum;
   logic signed [63:0]        r_val, floor_lim;
   logic signed [31:0]        q_sum;
   logic                      op_state;

   always_comb begin
      r0      = NUM_W'(pair_counts[0]) + NUM_W'(pair_counts[1]) + NUM_W'(pair_counts[2]);
      r1      = NUM_W'(pair_counts[3]) + NUM_W'(pair_counts[4]) + NUM_W'(pair_counts[5]);
      c0      = NUM_W'(pair_counts[0]) + NUM_W'(pair_counts[3]) + NUM_W'(pair_counts[6]);
      c1      = NUM_W'(pair_counts[1]) + NUM_W'(pair_counts[4]) + NUM_W'(pair_counts[7]);
      num1_c  = (r0 << 1) + r1;
      num2_c  = (c0 << 1) + c1;
      s_c     = (NUM_W'(pair_counts[0]) << 1) + NUM_W'(pair_counts[1])
                + NUM_W'(pair_counts[3]);
      n2      = {called_count, 1'b0};
      n4      = {called_count, 2'b00};
      tot2    = {site_count, 1'b0};
      sn      = (NUM_W+1)'(n22_ff) + ((NUM_W+1)'(s_ff) << 1);
      cov_lhs = (CNT_W+7)'(called_count) * (CNT_W+7)'(gld_pkg::PCT_MAX);
      cov_rhs = (CNT_W+7)'(min_cov) * (CNT_W+7)'(site_count);
      cov_low = (called_count == '0) || (site_count == '0) || (cov_lhs < cov_rhs);
      fixed   = (num1_c == '0) || (num1_c == n2) || (num2_c == '0) || (num2_c == n2);
      mid_sum = 33'(lo_ff) + 33'(hi_ff);
      narrow  = (hi_ff - lo_ff) < gld_pkg::Q_EPS;
      r_val   = acc_ff + 64'(cd_ff);
      bad_v   = (v1_ff <= 32'sd0) || (v2_ff <= 32'sd0);
      floor_lim = $signed({33'd0, min_r2, 24'd0});
      r2_low  = tmp_ff < floor_lim;
      q_sum   = gld_pkg::Q_ONE - p1_ff - p2_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gld_pkg::S_IDLE:  if (start) state_in = gld_pkg::S_CHECK;
         gld_pkg::S_CHECK: state_in = (cov_low || fixed) ? gld_pkg::S_OUT : gld_pkg::S_P1;
         gld_pkg::S_P1:    if (alu_done) state_in = gld_pkg::S_P2;
         gld_pkg::S_P2:    if (alu_done) state_in = gld_pkg::S_PQ;
         gld_pkg::S_PQ:    if (alu_done) state_in = gld_pkg::S_CB_M;
         gld_pkg::S_CB_M:  if (alu_done) state_in = gld_pkg::S_CB_D;
         gld_pkg::S_CB_D:  if (alu_done) state_in = gld_pkg::S_CC_M1;
         gld_pkg::S_CC_M1: if (alu_done) state_in = gld_pkg::S_CC_M2;
         gld_pkg::S_CC_M2: if (alu_done) state_in = gld_pkg::S_CC_M3;
         gld_pkg::S_CC_M3: if (alu_done) state_in = gld_pkg::S_CC_D;
         gld_pkg::S_CC_D:  if (alu_done) state_in = gld_pkg::S_CD_M;
         gld_pkg::S_CD_M:  if (alu_done) state_in = gld_pkg::S_CD_D;
         gld_pkg::S_CD_D:  if (alu_done) state_in = gld_pkg::S_LO;
         gld_pkg::S_LO:    if (alu_done) state_in = gld_pkg::S_HI;
         gld_pkg::S_HI:    if (alu_done) state_in = gld_pkg::S_MID;
         gld_pkg::S_MID: begin
            state_in = (narrow || (k_ff == KW'(BISECT_STEPS))) ? gld_pkg::S_V1 : gld_pkg::S_X2;
         end
         gld_pkg::S_X2:    if (alu_done) state_in = gld_pkg::S_X3;
         gld_pkg::S_X3:    if (alu_done) state_in = gld_pkg::S_BX2;
         gld_pkg::S_BX2:   if (alu_done) state_in = gld_pkg::S_CX;
         gld_pkg::S_CX:    if (alu_done) state_in = gld_pkg::S_EVAL;
         gld_pkg::S_EVAL:  state_in = (r_val == 64'sd0) ? gld_pkg::S_V1 : gld_pkg::S_MID;
         gld_pkg::S_V1:    if (alu_done) state_in = gld_pkg::S_V2;
         gld_pkg::S_V2:    if (alu_done) state_in = gld_pkg::S_VCHK;
         gld_pkg::S_VCHK:  state_in = bad_v ? gld_pkg::S_OUT : gld_pkg::S_DD_M;
         gld_pkg::S_DD_M:  if (alu_done) state_in = gld_pkg::S_R2A;
         gld_pkg::S_R2A:   if (alu_done) state_in = gld_pkg::S_R2B;
         gld_pkg::S_R2B:   if (alu_done) state_in = gld_pkg::S_FLOOR;
         gld_pkg::S_FLOOR: if (alu_done) state_in = gld_pkg::S_FCHK;
         gld_pkg::S_FCHK:  state_in = r2_low ? gld_pkg::S_OUT : gld_pkg::S_LD;
         gld_pkg::S_LD:    if (alu_done) state_in = gld_pkg::S_COV;
         gld_pkg::S_COV:   if (alu_done) state_in = gld_pkg::S_OUT;
         gld_pkg::S_OUT:   if (slot_free) state_in = gld_pkg::S_IDLE;
         default:          state_in = gld_pkg::S_IDLE;
      endcase
   end

   // outputs: operands of the shared unit and the finished result
   always_comb begin
      op_state   = 1'b1;
      alu_req.op = gld_pkg::ALU_MUL;
      alu_a      = '0;
      alu_b      = '0;
      unique case (state_ff)
         gld_pkg::S_P1: begin
            alu_req.op = gld_pkg::ALU_DIV;
            alu_a = $signed(64'(num1_c)) <<< gld_pkg::QF;
            alu_b = $signed(32'(n2));
         end
         gld_pkg::S_P2: begin
            alu_req.op = gld_pkg::ALU_DIV;
            alu_a = $signed(64'(num2_c)) <<< gld_pkg::QF;
            alu_b = $signed(32'(n2));
         end
         gld_pkg::S_PQ: begin
            alu_req.op = gld_pkg::ALU_QMUL;
            alu_a = 64'(p1_ff);
            alu_b = p2_ff;
         end
         gld_pkg::S_CB_M: begin
            alu_a = $signed(64'(n2));
            alu_b = t_ff;
         end
         gld_pkg::S_CB_D, gld_pkg::S_CC_D, gld_pkg::S_CD_D: begin
            alu_req.op = gld_pkg::ALU_DIV;
            alu_a = tmp_ff;
            alu_b = $signed(32'(n4));
         end
         gld_pkg::S_CC_M1: begin
            alu_a = $signed(64'(n2));
            alu_b = pq_ff;
         end
         gld_pkg::S_CC_M2: begin
            alu_a = $signed(64'(n22_ff));
            alu_b = q_sum;
         end
         gld_pkg::S_CC_M3: begin
            alu_a = $signed(64'(s_ff));
            alu_b = t_ff;
         end
         gld_pkg::S_CD_M: begin
            alu_a = 64'(pq_ff);
            alu_b = $signed(32'(s_ff));
         end
         gld_pkg::S_LO: begin
            alu_req.op = gld_pkg::ALU_DIV;
            alu_a = $signed(64'(s_ff)) <<< gld_pkg::QF;
            alu_b = $signed(32'(n2));
         end
         gld_pkg::S_HI: begin
            alu_req.op = gld_pkg::ALU_DIV;
            alu_a = $signed(64'(sn - (NUM_W+1)'(s_ff))) <<< gld_pkg::QF;
            alu_b = $signed(32'(n2));
         end
         gld_pkg::S_X2: begin
            alu_req.op = gld_pkg::ALU_QMUL;
            alu_a = 64'(mid_ff);
            alu_b = mid_ff;
         end
         gld_pkg::S_X3: begin
            alu_req.op = gld_pkg::ALU_QMUL;
            alu_a = 64'(x2_ff);
            alu_b = mid_ff;
         end
         gld_pkg::S_BX2: begin
            alu_req.op = gld_pkg::ALU_QMUL;
            alu_a = 64'(cb_ff);
            alu_b = x2_ff;
         end
         gld_pkg::S_CX: begin
            alu_req.op = gld_pkg::ALU_QMUL;
            alu_a = 64'(cc_ff);
            alu_b = mid_ff;
         end
         gld_pkg::S_V1: begin
            alu_req.op = gld_pkg::ALU_QMUL;
            alu_a = 64'(p1_ff);
            alu_b = gld_pkg::Q_ONE - p1_ff;
         end
         gld_pkg::S_V2: begin
            alu_req.op = gld_pkg::ALU_QMUL;
            alu_a = 64'(p2_ff);
            alu_b = gld_pkg::Q_ONE - p2_ff;
         end
         gld_pkg::S_DD_M: begin
            alu_a = 64'(dd_ff);
            alu_b = dd_ff;
         end
         gld_pkg::S_R2A: begin
            alu_req.op = gld_pkg::ALU_DIV;
            alu_a = tmp_ff;
            alu_b = v1_ff;
         end
         gld_pkg::S_R2B: begin
            alu_req.op = gld_pkg::ALU_DIV;
            alu_a = 64'(r2_ff) <<< gld_pkg::QF;
            alu_b = v2_ff;
         end
         gld_pkg::S_FLOOR: begin
            alu_a = 64'(r2_ff);
            alu_b = 32'sd100;
         end
         gld_pkg::S_LD: begin
            // rounded r2 times 100 back to an integer
            alu_req.op = gld_pkg::ALU_QMUL;
            alu_a = 64'(r2_ff);
            alu_b = 32'sd100;
         end
         gld_pkg::S_COV: begin
            alu_req.op = gld_pkg::ALU_DIV;
            alu_a = $signed(64'(called_count)) * 64'sd200;
            alu_b = $signed(32'(tot2));
         end
         default: op_state = 1'b0;
      endcase
      alu_req.start = op_state && !wait_ff;
      result.valid  = (state_ff == gld_pkg::S_OUT);
      result.ld     = ld_ff;
      result.cov    = cov_ff;
      result.status = status_ff;
      idle          = (state_ff == gld_pkg::S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gld_pkg::S_IDLE;
         wait_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (alu_req.start) begin
            wait_ff <= 1'b1;
         end else if (alu_done) begin
            wait_ff <= 1'b0;
         end
      end
   end

   // capture results of the shared unit and the solver's own working values
   always_ff @(posedge clock) begin
      case (state_ff)
         gld_pkg::S_CHECK: begin
            s_ff   <= s_c;
            n22_ff <= NUM_W'(pair_counts[4]);
            ld_ff  <= '0;
            cov_ff <= '0;
            status_ff <= cov_low ? gld_pkg::STAT_LOW_COV :
                         fixed   ? gld_pkg::STAT_FIXED   : gld_pkg::STAT_OK;
         end
         gld_pkg::S_P1: if (alu_done) p1_ff <= alu_res[31:0];
         gld_pkg::S_P2: begin
            if (alu_done) begin
               p2_ff <= alu_res[31:0];
               t_ff  <= gld_pkg::Q_ONE - (p1_ff <<< 1) - (alu_res[31:0] <<< 1);
            end
         end
         gld_pkg::S_PQ:    if (alu_done) pq_ff <= alu_res[31:0];
         gld_pkg::S_CB_M:  if (alu_done) tmp_ff <= alu_res - ($signed(64'(sn)) <<< gld_pkg::QF);
         gld_pkg::S_CB_D:  if (alu_done) cb_ff <= alu_res[31:0];
         gld_pkg::S_CC_M1: if (alu_done) tmp_ff <= alu_res;
         gld_pkg::S_CC_M2, gld_pkg::S_CC_M3: if (alu_done) tmp_ff <= tmp_ff - alu_res;
         gld_pkg::S_CC_D:  if (alu_done) cc_ff <= alu_res[31:0];
         gld_pkg::S_CD_M:  if (alu_done) tmp_ff <= -alu_res;
         gld_pkg::S_CD_D:  if (alu_done) cd_ff <= alu_res[31:0];
         gld_pkg::S_LO:    if (alu_done) lo_ff <= alu_res[31:0];
         gld_pkg::S_HI: begin
            if (alu_done) begin
               hi_ff <= alu_res[31:0];
               k_ff  <= '0;
            end
         end
         gld_pkg::S_MID:   mid_ff <= mid_sum[32:1];
         gld_pkg::S_X2:    if (alu_done) x2_ff <= alu_res[31:0];
         gld_pkg::S_X3:    if (alu_done) acc_ff <= alu_res;
         gld_pkg::S_BX2, gld_pkg::S_CX: if (alu_done) acc_ff <= acc_ff + alu_res;
         gld_pkg::S_EVAL: begin
            // keep the lower half when the cubic is positive
            if (r_val != 64'sd0) begin
               if (r_val > 64'sd0) begin
                  hi_ff <= mid_ff;
               end else begin
                  lo_ff <= mid_ff;
               end
               k_ff <= k_ff + 1'b1;
            end
         end
         gld_pkg::S_V1:    if (alu_done) v1_ff <= alu_res[31:0];
         gld_pkg::S_V2:    if (alu_done) v2_ff <= alu_res[31:0];
         gld_pkg::S_VCHK: begin
            dd_ff <= mid_ff - pq_ff;
            if (bad_v) status_ff <= gld_pkg::STAT_FIXED;
         end
         gld_pkg::S_DD_M:  if (alu_done) tmp_ff <= alu_res;
         gld_pkg::S_R2A: begin
            if (alu_done) begin
               r2_ff <= (alu_res > gld_pkg::Q_FOUR) ? gld_pkg::Q_FOUR[31:0] : alu_res[31:0];
            end
         end
         gld_pkg::S_R2B: begin
            if (alu_done) begin
               r2_ff <= (alu_res > gld_pkg::Q_TWO) ? gld_pkg::Q_TWO[31:0] : alu_res[31:0];
            end
         end
         gld_pkg::S_FLOOR: if (alu_done) tmp_ff <= alu_res;
         gld_pkg::S_FCHK:  if (r2_low) status_ff <= gld_pkg::STAT_WEAK;
         gld_pkg::S_LD: begin
            if (alu_done) begin
               ld_ff <= (alu_res > 64'sd100) ? gld_pkg::PCT_MAX : alu_res[6:0];
            end
         end
         gld_pkg::S_COV:   if (alu_done) cov_ff <= alu_res[6:0];
         default: ;
      endcase
   end

endmodule

/* hw/rtl/genotype_ld_r2.sv */
// Channel   Direction  Transfer carries
// req_*     in         one site: two genotype codes, last-site mark
// rsp_*     out        one r2 result per run, status in tuser
// csr_*     in         register writes, no read-back
//
// Sites are taken one per cycle while a run is being counted.
// A last site starts the solve, with up to BISECT_STEPS bisection steps;
// ten divides in the shared unit take most of its time. req_tready is low
// during the solve and while a result waits for a full output register.
// Low coverage or a fixed allele ends the solve at the check, before any divide.
// The result sits in an output register; the next run may start counting
// while it waits. Reset is synchronous and clears all counts.
`include "genotype_ld_r2_macros.svh"

module genotype_ld_r2 #(
   parameter int MAX_SITES    = 512,
   parameter int BISECT_STEPS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // geno_a[1:0], geno_b[3:2], zero pad
   input  logic        req_tlast,   // last_site
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // ld_percent[6:0], coverage_percent[13:7], zero pad
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata
);

   localparam int CNT_W = $clog2(MAX_SITES + 1);

   logic [6:0]                min_cov_ff, min_r2_ff;
   logic                      rsp_valid_ff;
   logic [15:0]               rsp_data_ff;
   logic [1:0]                rsp_user_ff;

   logic                      accept, slot_free, solver_idle, alu_done;
   logic [CNT_W-1:0]          site_count, called_count;
   logic [8:0][CNT_W-1:0]     pair_counts;
   gld_pkg::alu_req_type      alu_req;
   gld_pkg::result_type       result;
   logic signed [63:0]        alu_a, alu_res;
   logic signed [31:0]        alu_b;

   assign req_tready = solver_idle;
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_cov_ff <= 7'd10;
         min_r2_ff  <= 7'd10;
      end else if (csr_we) begin
         unique case (csr_index)
            gld_pkg::CSR_MIN_COV: min_cov_ff <= csr_wdata;
            gld_pkg::CSR_MIN_R2:  min_r2_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   gld_count #(
      .MAX_SITES (MAX_SITES),
      .CNT_W     (CNT_W)
   ) u_count (
      .clock        (clock),
      .reset        (reset),
      .inc          (accept),
      .clear        (result.valid && slot_free),
      .geno_a       (req_tdata[1:0]),
      .geno_b       (req_tdata[3:2]),
      .site_count   (site_count),
      .called_count (called_count),
      .pair_counts  (pair_counts)
   );

   gld_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (alu_req),
      .opa    (alu_a),
      .opb    (alu_b),
      .done   (alu_done),
      .result (alu_res)
   );

   gld_solve #(
      .CNT_W        (CNT_W),
      .BISECT_STEPS (BISECT_STEPS)
   ) u_solve (
      .clock        (clock),
      .reset        (reset),
      .start        (accept && req_tlast),
      .slot_free    (slot_free),
      .site_count   (site_count),
      .called_count (called_count),
      .pair_counts  (pair_counts),
      .min_cov      (min_cov_ff),
      .min_r2       (min_r2_ff),
      .alu_done     (alu_done),
      .alu_res      (alu_res),
      .alu_req      (alu_req),
      .alu_a        (alu_a),
      .alu_b        (alu_b),
      .result       (result),
      .idle         (solver_idle)
   );

   // hold the result until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.valid && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid && slot_free) begin
         rsp_data_ff <= {2'b00, result.cov, result.ld};
         rsp_user_ff <= result.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `GLD_ASSERT_NEXT(a_busy_after_last, clock, reset, accept && req_tlast, !req_tready,
      "input still ready after a last site")
   `GLD_ASSERT_IMP(a_zero_unless_ok, clock, reset,
      rsp_valid_ff && (rsp_user_ff != gld_pkg::STAT_OK), rsp_data_ff == 16'd0,
      "non-ok result carries nonzero percentages")
   `GLD_ASSERT_IMP(a_pct_range, clock, reset,
      rsp_valid_ff && (rsp_user_ff == gld_pkg::STAT_OK),
      (rsp_data_ff[6:0] <= gld_pkg::PCT_MAX) && (rsp_data_ff[13:7] <= gld_pkg::PCT_MAX),
      "percentage above 100")
   `GLD_ASSERT_IMP(a_site_bound, clock, reset, 1'b1, site_count <= CNT_W'(MAX_SITES),
      "site count beyond run limit")

endmodule
